>>> sv/binary128_to_decimal_ascii_assert.svh
// assertion macros for the binary to decimal ascii converter
// used by the top level only; needs clk and arst_n in scope
`ifndef BINARY128_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY128_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication, checked out of reset
`define B2DA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("b2da assertion failed");

// next-cycle implication, checked out of reset
`define B2DA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("b2da assertion failed");

`endif

>>> sv/b2da_pkg.sv
// shared constants and types for the binary to decimal ascii converter
// no dependencies
`default_nettype none

package b2da_pkg;

	// default width of the converted value
	localparam int VALUE_BITS_DEF = 128;

	// fixed widths of the stream fields
	localparam int HALF_W  = 64;
	localparam int IN_W    = 2 * HALF_W;
	localparam int CHAR_W  = 8;

	// ascii codes
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
	localparam logic [CHAR_W-1:0] ASCII_NINE = 8'd57;
	localparam logic [CHAR_W-1:0] ASCII_NL   = 8'd10;

	// bcd digit width
	localparam int BCD_DIGIT_W = 4;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

>>> sv/binary128_to_decimal_ascii.sv
// top level of the binary to decimal ascii converter
// depends on b2da_pkg, b2da_front, b2da_queue, b2da_back and the assertion header
//
// channel   dir  beat                         fields
// s_axis    in   one value to convert         tdata: value_high, value_low
// m_axis    out  one character of the text    tdata: char_code; tlast: last
//
// a value is loaded, converted to bcd by shift-and-add-3 over its VALUE_BITS bits,
// stripped of its leading zero digits, and then sent as its digits followed by the
// newline.
// reset clears all control state at once; there is no clearing pass.
// the front holds one value and the queue two more while the back is busy;
// a stalled output holds the back end in place.
`default_nettype none

module binary128_to_decimal_ascii import b2da_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire  [IN_W-1:0]   s_axis_tdata,   // value_high [63:0], value_low [127:64]
	output logic              m_axis_tvalid,
	input  wire               m_axis_tready,
	output logic [CHAR_W-1:0] m_axis_tdata,   // char_code [7:0]
	output logic              m_axis_tlast    // last
);

`include "binary128_to_decimal_ascii_assert.svh"

	q_status_t             q_status;
	logic                  q_push;
	logic                  q_pop;
	logic [VALUE_BITS-1:0] q_wdata;
	logic [VALUE_BITS-1:0] q_rdata;

	// accept and mask
	b2da_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_status      (q_status),
		.q_push        (q_push),
		.q_wdata       (q_wdata)
	);

	// decoupling queue
	b2da_queue #(.VALUE_BITS(VALUE_BITS)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.status (q_status)
	);

	// conversion and character output
	b2da_back #(.VALUE_BITS(VALUE_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.q_rdata       (q_rdata),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// checks on the output text and the queue
	`B2DA_ASSERT_IMP(a_last_is_newline, m_axis_tvalid && m_axis_tlast, m_axis_tdata == ASCII_NL)
	`B2DA_ASSERT_IMP(a_body_is_digit, m_axis_tvalid && !m_axis_tlast, m_axis_tdata >= ASCII_ZERO && m_axis_tdata <= ASCII_NINE)
	`B2DA_ASSERT_IMP(a_no_overflow, q_push, !q_status.full)
	`B2DA_ASSERT_IMP(a_no_underflow, q_status.empty, !q_pop)
	`B2DA_ASSERT_NXT(a_out_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

`default_nettype wire

>>> sv/b2da_front.sv
// front end: accepts input beats, masks the value to its width, hands it to the queue
// depends on b2da_pkg
`default_nettype none

module b2da_front import b2da_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire  [IN_W-1:0]       s_axis_tdata,   // value_high [63:0], value_low [127:64]
	input  q_status_t             q_status,
	output logic                  q_push,
	output logic [VALUE_BITS-1:0] q_wdata
);

	logic                  held_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [IN_W-1:0]       joined;
	logic                  take;

	// rebuild the 128-bit value: high half over low half
	assign joined = {s_axis_tdata[HALF_W-1:0], s_axis_tdata[IN_W-1:HALF_W]};

	// one holding stage; free when empty or draining into the queue
	assign q_push        = held_q && !q_status.full;
	assign s_axis_tready = !held_q || !q_status.full;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign q_wdata       = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
		end else if (take) begin
			held_q <= 1'b1;
		end else if (q_push) begin
			held_q <= 1'b0;
		end
	end

	// bits above the value width are dropped here
	always_ff @(posedge clk) begin
		if (take) begin
			value_q <= joined[VALUE_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

>>> sv/b2da_queue.sv
// short fifo between front and back ends
// depends on b2da_pkg
`default_nettype none

module b2da_queue import b2da_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire  [VALUE_BITS-1:0] wdata,
	input  wire                   pop,
	output logic [VALUE_BITS-1:0] rdata,
	output q_status_t             status
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [VALUE_BITS-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;

	assign status.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign rdata        = entry_q[rd_ptr_q];

	// pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

>>> sv/b2da_back.sv
// back end: shift-and-add-3 conversion to bcd, leading zero skip, character output
// depends on b2da_pkg
`default_nettype none

module b2da_back import b2da_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  q_status_t             q_status,
	input  wire  [VALUE_BITS-1:0] q_rdata,
	output logic                  q_pop,
	output logic                  m_axis_tvalid,
	input  wire                   m_axis_tready,
	output logic [CHAR_W-1:0]     m_axis_tdata,   // char_code [7:0]
	output logic                  m_axis_tlast    // last
);

	// enough decimal digits for any value of the given width
	localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_W  = DIGITS * BCD_DIGIT_W;
	localparam int CNT_W  = $clog2(VALUE_BITS + 1);
	localparam int LEFT_W = $clog2(DIGITS + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SKIP = 5'b00100,
		ST_EMIT = 5'b01000,
		ST_NL   = 5'b10000
	} conv_state_t;

	conv_state_t           state_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;
	logic [CNT_W-1:0]      cnt_q;
	logic [LEFT_W-1:0]     left_q;
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     out_data_q;
	logic                  out_last_q;
	logic                  out_free;
	logic [BCD_DIGIT_W-1:0] top_digit;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign top_digit     = bcd_q[BCD_W-1 -: BCD_DIGIT_W];
	assign q_pop         = (state_q == ST_IDLE) && !q_status.empty;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[d*BCD_DIGIT_W +: BCD_DIGIT_W] >= 4'd5) begin
				bcd_adj[d*BCD_DIGIT_W +: BCD_DIGIT_W] =
					bcd_q[d*BCD_DIGIT_W +: BCD_DIGIT_W] + 4'd3;
			end else begin
				bcd_adj[d*BCD_DIGIT_W +: BCD_DIGIT_W] = bcd_q[d*BCD_DIGIT_W +: BCD_DIGIT_W];
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			left_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_status.empty) begin
						cnt_q   <= CNT_W'(VALUE_BITS);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						left_q  <= LEFT_W'(DIGITS);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (top_digit == '0 && left_q != LEFT_W'(1)) begin
						left_q <= left_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						left_q <= left_q - 1'b1;
						if (left_q == LEFT_W'(1)) begin
							state_q <= ST_NL;
						end
					end
				end
				ST_NL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers of the conversion
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!q_status.empty) begin
					bin_q <= q_rdata;
					bcd_q <= '0;
				end
			end
			ST_CONV: begin
				bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
				bin_q <= bin_q << 1;
			end
			ST_SKIP: begin
				if (top_digit == '0 && left_q != LEFT_W'(1)) begin
					bcd_q <= bcd_q << BCD_DIGIT_W;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					bcd_q <= bcd_q << BCD_DIGIT_W;
				end
			end
			default: begin
			end
		endcase
	end

	// output register, one beat held while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == ST_EMIT) || (state_q == ST_NL);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_NL) begin
				out_data_q <= ASCII_NL;
				out_last_q <= 1'b1;
			end else begin
				out_data_q <= ASCII_ZERO + CHAR_W'(top_digit);
				out_last_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for binary128_to_decimal_ascii: directed and random values,
// predicted decimal text compared beat by beat; depends on b2da_pkg and the top level

module testbench;
	import b2da_pkg::*;

	localparam int CONV_BITS        = VALUE_BITS_DEF;
	localparam int RESET_CYCLES     = 9;
	localparam int RANDOM_PER_PHASE = 100;
	localparam int HOLD_AFTER_BEATS = 200;
	localparam int HOLD_CYCLES      = 400;
	localparam int TAIL_CYCLES      = 200;
	localparam int QUIET_LIMIT      = 5000;
	localparam int MAX_CHARS        = 40;

	typedef struct {
		bit [HALF_W-1:0] high;
		bit [HALF_W-1:0] low;
	} value_t;

	typedef struct {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [CHAR_W-1:0] m_axis_tdata;
	logic              m_axis_tlast;

	value_t     pending_values[$];
	text_char_t expected_text[$];
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         char_beats = 0;
	int         failures = 0;
	int         quiet_cycles = 0;
	logic       hold_active = 1'b0;

	binary128_to_decimal_ascii dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// decimal text of one value: digits most significant first, then the newline
	function automatic void predict_decimal_text(input value_t item);
		bit [IN_W-1:0]     v;
		bit [IN_W-1:0]     mask;
		logic [CHAR_W-1:0] digs[MAX_CHARS];
		int                nd;
		text_char_t        c;
		mask = (CONV_BITS >= IN_W) ? '1 : ((IN_W'(1) << CONV_BITS) - 1);
		v = {item.high, item.low} & mask;
		nd = 0;
		if (v == 0) begin
			digs[0] = ASCII_ZERO;
			nd = 1;
		end
		while (v != 0) begin
			digs[nd] = ASCII_ZERO + CHAR_W'(v % 10);
			v = v / 10;
			nd++;
		end
		while (nd > 0) begin
			nd--;
			c.code = digs[nd];
			c.last = 1'b0;
			expected_text.push_back(c);
		end
		c.code = ASCII_NL;
		c.last = 1'b1;
		expected_text.push_back(c);
	endfunction

	function automatic bit [IN_W-1:0] pow10(input int k);
		bit [IN_W-1:0] p;
		p = 1;
		repeat (k) p = p * 10;
		return p;
	endfunction

	function automatic void queue_value(input bit [IN_W-1:0] v);
		value_t item;
		item.high = v[IN_W-1:HALF_W];
		item.low  = v[HALF_W-1:0];
		pending_values.push_back(item);
	endfunction

	// random value, weighted towards varied digit counts and decade edges
	function automatic bit [IN_W-1:0] random_value();
		bit [IN_W-1:0] v;
		int            pick;
		int            len;
		v = {$urandom, $urandom, $urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 50) begin
			// random bit length, top bit set
			len = $urandom_range(IN_W, 1);
			if (len < IN_W)
				v = v & ((IN_W'(1) << len) - 1);
			v[len-1] = 1'b1;
		end else if (pick < 65) begin
			v = v;
		end else if (pick < 80) begin
			// around a power of ten
			v = pow10($urandom_range(38, 0)) + IN_W'($urandom_range(2, 0)) - 1;
		end else if (pick < 90) begin
			v = IN_W'($urandom_range(999, 0));
		end else begin
			// one half empty or saturated
			case ($urandom_range(3))
				0: v[IN_W-1:HALF_W] = '0;
				1: v[HALF_W-1:0] = '0;
				2: v[IN_W-1:HALF_W] = '1;
				default: v[HALF_W-1:0] = '1;
			endcase
		end
		return v;
	endfunction

	// sender: holds a beat until taken, predicts on acceptance
	always @(posedge clk or negedge arst_n) begin : send_side
		logic offer;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			offer = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				predict_decimal_text(pending_values[0]);
				void'(pending_values.pop_front());
				offer = 1'b0;
			end
			if (!offer && pending_values.size() > 0 && $urandom_range(99) >= send_idle_pct)
				offer = 1'b1;
			s_axis_tvalid <= offer;
			if (offer)
				s_axis_tdata <= {pending_values[0].low, pending_values[0].high};
		end
	end

	// receiver: checks each character beat against the oldest expectation
	always @(posedge clk or negedge arst_n) begin : recv_side
		text_char_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				char_beats++;
				if (expected_text.size() == 0) begin
					$error("unexpected beat: char_code %0d last %0b", m_axis_tdata, m_axis_tlast);
					failures++;
				end else begin
					want = expected_text.pop_front();
					if (m_axis_tdata !== want.code) begin
						$error("char_code mismatch: expected %0d, got %0d", want.code, m_axis_tdata);
						failures++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last mismatch: expected %0b, got %0b", want.last, m_axis_tlast);
						failures++;
					end
				end
			end
			m_axis_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// long output hold-off so the value queue fills and input stalls
	initial begin : receiver_hold
		while (char_beats < HOLD_AFTER_BEATS) @(posedge clk);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("** binary128_to_decimal_ascii: FAILED **");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic run_phase(input int idle_pct, input int stall_pct, input int items);
		send_idle_pct  <= idle_pct;
		recv_stall_pct <= stall_pct;
		repeat (items) queue_value(random_value());
		while (pending_values.size() != 0 || expected_text.size() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, decade edges, bit patterns
		queue_value('0);
		queue_value(1);
		queue_value(9);
		queue_value(10);
		queue_value(99);
		queue_value(100);
		queue_value('1);
		queue_value({{HALF_W{1'b0}}, {HALF_W{1'b1}}});
		queue_value({{(HALF_W-1){1'b0}}, 1'b1, {HALF_W{1'b0}}});
		queue_value({{HALF_W{1'b1}}, {HALF_W{1'b0}}});
		queue_value({1'b1, {(IN_W-1){1'b0}}});
		queue_value({{(HALF_W+1){1'b0}}, 1'b1, {(HALF_W-2){1'b0}}});
		queue_value({(IN_W/2){2'b10}});
		queue_value({(IN_W/2){2'b01}});
		queue_value(pow10(19) - 1);
		queue_value(pow10(19));
		queue_value(pow10(38) - 1);
		queue_value(pow10(38));
		queue_value(pow10(38) + 1);
		queue_value(0);

		run_phase(0, 0, RANDOM_PER_PHASE);
		run_phase(50, 0, RANDOM_PER_PHASE);
		run_phase(0, 50, RANDOM_PER_PHASE);
		run_phase(19, 19, RANDOM_PER_PHASE);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("** binary128_to_decimal_ascii: PASSED **");
		else
			$display("** binary128_to_decimal_ascii: FAILED **");
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/b2da_pkg.sv
sv/b2da_front.sv
sv/b2da_queue.sv
sv/b2da_back.sv
sv/binary128_to_decimal_ascii.sv
tb/sv/testbench.sv
